@@ rtl/mpw_pkg.sv @@
// ----------------------------------------------------------------------------
// mpw_pkg: shared types and constants of the int8 max pool window block
// Holds the register map, the front-to-back queue word and the back FSM states.
// ----------------------------------------------------------------------------
package mpw_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_IN_HEIGHT = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH  = 3'd1;
	localparam logic [2:0] REG_WIN_ROWS  = 3'd2;
	localparam logic [2:0] REG_WIN_COLS  = 3'd3;
	localparam logic [2:0] REG_ACT_MIN   = 3'd4;
	localparam logic [2:0] REG_ACT_MAX   = 3'd5;

	// item kinds carried in tuser
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// running maximum starts here
	localparam logic signed [7:0] BEST_INIT = -8'sd128;

	// entries of the front-to-back queue
	localparam int QDEPTH = 2;

	// one classified word: a load to write, or a query with its clipped window
	typedef struct packed {
		logic        is_query;
		logic        empty;     // query window clipped to nothing, or channel out of range
		logic [5:0]  r0;        // first row (load: element row)
		logic [5:0]  r1;        // row past the last one
		logic [5:0]  c0;        // first column (load: element column)
		logic [5:0]  c1;        // column past the last one
		logic [5:0]  chan;
		logic [7:0]  value;
	} mpw_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_FINISH
	} mpw_state_t;

endpackage

@@ rtl/mpw_front.sv @@
// ----------------------------------------------------------------------------
// mpw_front: input classification
// Drops loads outside the store and clips query windows to the map.
// ----------------------------------------------------------------------------
module mpw_front #(
	parameter int MAX_HEIGHT = 32,
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_DEPTH  = 64
) (
	input  logic                 func,
	input  logic signed [5:0]    window_row,
	input  logic signed [5:0]    window_col,
	input  logic [5:0]           chan,
	input  logic [7:0]           value,
	input  logic [5:0]           in_height,
	input  logic [5:0]           in_width,
	input  logic [4:0]           win_rows,
	input  logic [4:0]           win_cols,
	output logic                 keep,
	output mpw_pkg::mpw_op_t     op
);

	logic signed [7:0] row_x, col_x;
	logic signed [7:0] h_lim, w_lim;
	logic signed [7:0] r_end, c_end, r_lo, c_lo, r_hi, c_hi;
	logic [5:0]        h_cl, w_cl;
	logic              load_ok, chan_ok;

	always_comb begin
		row_x = {{2{window_row[5]}}, window_row};
		col_x = {{2{window_col[5]}}, window_col};

		// map size limited by the store
		h_cl = (int'(in_height) < MAX_HEIGHT) ? in_height : 6'(MAX_HEIGHT);
		w_cl = (int'(in_width) < MAX_WIDTH) ? in_width : 6'(MAX_WIDTH);
		h_lim = signed'({2'b00, h_cl});
		w_lim = signed'({2'b00, w_cl});

		r_end = row_x + signed'({3'b000, win_rows});
		c_end = col_x + signed'({3'b000, win_cols});
		r_lo = (row_x < 8'sd0) ? 8'sd0 : row_x;
		c_lo = (col_x < 8'sd0) ? 8'sd0 : col_x;
		r_hi = (r_end < h_lim) ? r_end : h_lim;
		c_hi = (c_end < w_lim) ? c_end : w_lim;

		chan_ok = int'(chan) < MAX_DEPTH;
		load_ok = (row_x >= 8'sd0) && (int'(row_x) < MAX_HEIGHT)
			&& (col_x >= 8'sd0) && (int'(col_x) < MAX_WIDTH) && chan_ok;

		op.is_query = (func == mpw_pkg::FUNC_QUERY);
		op.empty    = (r_lo >= r_hi) || (c_lo >= c_hi) || !chan_ok;
		op.chan     = chan;
		op.value    = value;
		op.r1       = r_hi[5:0];
		op.c1       = c_hi[5:0];
		if (op.is_query) begin
			op.r0 = r_lo[5:0];
			op.c0 = c_lo[5:0];
		end else begin
			op.r0 = window_row;
			op.c0 = window_col;
		end

		// a load outside the store has no effect: drop it here
		keep = op.is_query || load_ok;
	end

endmodule

@@ rtl/mpw_queue.sv @@
// ----------------------------------------------------------------------------
// mpw_queue: short queue between front and back
// Two-entry FIFO of classified words.
// ----------------------------------------------------------------------------
module mpw_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mpw_pkg::mpw_op_t     push_op,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output mpw_pkg::mpw_op_t     head
);

	localparam int PW = (mpw_pkg::QDEPTH > 1) ? $clog2(mpw_pkg::QDEPTH) : 1;

	mpw_pkg::mpw_op_t  slot_q [mpw_pkg::QDEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;

	assign full      = (int'(count_q) == mpw_pkg::QDEPTH);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == mpw_pkg::QDEPTH - 1) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == mpw_pkg::QDEPTH - 1) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			count_q <= (PW+1)'(count_q + (PW+1)'(push) - (PW+1)'(pop));
		end
	end

endmodule

@@ rtl/mpw_back.sv @@
// ----------------------------------------------------------------------------
// mpw_back: store, window walker and output register
// Writes loads, walks query windows one store read a cycle, clamps the maximum.
// ----------------------------------------------------------------------------
module mpw_back #(
	parameter int MAX_HEIGHT = 32,
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_DEPTH  = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  mpw_pkg::mpw_op_t     q_head,
	output logic                 q_pop,
	input  logic signed [7:0]    act_min,
	input  logic signed [7:0]    act_max,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata
);

	localparam int RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int DB    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int AW    = RB + CB + DB;
	localparam int DEPTH = 1 << AW;

	function automatic logic [AW-1:0] addr_of(input logic [5:0] r, input logic [5:0] c,
		input logic [5:0] ch);
		return (AW'(r) << (CB + DB)) | (AW'(c) << DB) | AW'(ch);
	endfunction

	logic signed [7:0]   mem [DEPTH];
	logic signed [7:0]   rdata_q;
	logic                rd_pend_q;

	mpw_pkg::mpw_state_t state_q, state_d;
	logic [5:0]          r_q, c_q, c0_q, r1_q, c1_q, chan_q;
	logic [5:0]          r_d, c_d;
	logic signed [7:0]   best_q, best_d, best_mrg, clamp_lo, clamp_res;
	logic                out_valid_q;
	logic [7:0]          out_data_q;
	logic                out_load, col_wrap, last_cell, mem_we;

	// merge the word read in the previous cycle
	assign best_mrg  = (rd_pend_q && (rdata_q > best_q)) ? rdata_q : best_q;
	assign clamp_lo  = (best_mrg < act_min) ? act_min : best_mrg;
	assign clamp_res = (clamp_lo > act_max) ? act_max : clamp_lo;

	assign col_wrap  = (6'(c_q + 6'd1) == c1_q);
	assign last_cell = col_wrap && (6'(r_q + 6'd1) == r1_q);
	assign mem_we    = q_pop && !q_head.is_query;

	always_comb begin
		state_d  = state_q;
		r_d      = r_q;
		c_d      = c_q;
		best_d   = best_mrg;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			mpw_pkg::BK_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_head.is_query) begin
					r_d    = q_head.r0;
					c_d    = q_head.c0;
					best_d = mpw_pkg::BEST_INIT;
					state_d = q_head.empty ? mpw_pkg::BK_FINISH : mpw_pkg::BK_WALK;
				end
			end
			mpw_pkg::BK_WALK: begin
				if (col_wrap) begin
					c_d = c0_q;
					r_d = 6'(r_q + 6'd1);
				end else begin
					c_d = 6'(c_q + 6'd1);
				end
				if (last_cell) begin
					state_d = mpw_pkg::BK_FINISH;
				end
			end
			mpw_pkg::BK_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = mpw_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = mpw_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_of(q_head.r0, q_head.c0, q_head.chan)] <= q_head.value;
		end
		rdata_q <= mem[addr_of(r_q, c_q, chan_q)];
	end

	always_ff @(posedge clk) begin
		r_q    <= r_d;
		c_q    <= c_d;
		best_q <= best_d;
		if (q_pop) begin
			c0_q   <= q_head.c0;
			r1_q   <= q_head.r1;
			c1_q   <= q_head.c1;
			chan_q <= q_head.chan;
		end
		if (out_load) begin
			out_data_q <= clamp_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpw_pkg::BK_IDLE;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= (state_q == mpw_pkg::BK_WALK);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_pend_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> $past(state_q == mpw_pkg::BK_WALK))
		else $error("read data pending without a walk cycle before it");

	a_walk_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpw_pkg::BK_WALK) |-> (r_q < r1_q) && (c_q < c1_q))
		else $error("window walker left the clipped window");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == mpw_pkg::BK_IDLE) && q_valid)
		else $error("queue popped outside idle or while empty");

	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpw_pkg::BK_FINISH && out_valid_q && !m_tready)
		|=> (state_q == mpw_pkg::BK_FINISH))
		else $error("result dropped while output register was full");

endmodule

@@ rtl/int8_max_pool_window_top.sv @@
// ----------------------------------------------------------------------------
// int8_max_pool_window_top: signed 8-bit 2D max pooling over a stored map
// Input stream carries loads and queries; output stream carries pooled values.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one word per load or query. tuser = func (0 load, 1 query).
//   A load writes one element at (row, col, chan); loads outside the store
//   are dropped. A query names a window origin (may be negative) and a
//   channel; the window is clipped to the map and its maximum, clamped to
//   [act_min, act_max], comes out on the m_* channel as one word.
//   Config: cfg_we/cfg_index/cfg_wdata write one register per cycle; write
//   only while the block is idle.
// Timing:
//   The front classifies and clips in the accepting cycle and queues the word
//   (two entries). The back takes one word at a time: a load is written to the
//   store in the cycle it is popped; a query walks each cell of its clipped
//   window with one store read each, set by the single read port of the feature
//   store (one read per cycle), then loads the output register.
// Reset: clears control registers, loads config defaults; the store keeps no reset
//   value and needs no clearing pass. Only loaded entries may be queried.
// Stall: the result waits in the output register while m_tready is low;
//   the back holds its finished query and the queue absorbs new words.
// ----------------------------------------------------------------------------
module int8_max_pool_window_top #(
	parameter int MAX_HEIGHT = 32,
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_DEPTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // window_row[5:0], window_col[11:6], chan[17:12],
	                              // value[25:18], zero fill [31:26]
	input  logic        s_tuser,  // func[0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // pooled_value[7:0]
);

	logic [5:0]        in_height_q, in_width_q;
	logic [4:0]        win_rows_q, win_cols_q;
	logic signed [7:0] act_min_q, act_max_q;

	logic              keep, q_full, q_push, q_pop, q_valid;
	mpw_pkg::mpw_op_t  front_op, q_head;

	// hold configuration; indexes beyond the map are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q <= 6'd32;
			in_width_q  <= 6'd32;
			win_rows_q  <= 5'd2;
			win_cols_q  <= 5'd2;
			act_min_q   <= -8'sd128;
			act_max_q   <= 8'sd127;
		end else if (cfg_we) begin
			case (cfg_index)
				mpw_pkg::REG_IN_HEIGHT: in_height_q <= cfg_wdata[5:0];
				mpw_pkg::REG_IN_WIDTH:  in_width_q  <= cfg_wdata[5:0];
				mpw_pkg::REG_WIN_ROWS:  win_rows_q  <= cfg_wdata[4:0];
				mpw_pkg::REG_WIN_COLS:  win_cols_q  <= cfg_wdata[4:0];
				mpw_pkg::REG_ACT_MIN:   act_min_q   <= signed'(cfg_wdata);
				mpw_pkg::REG_ACT_MAX:   act_max_q   <= signed'(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	// accept a word whenever the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready && keep;

	mpw_front #(
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_DEPTH  (MAX_DEPTH)
	) u_front (
		.func       (s_tuser),
		.window_row (signed'(s_tdata[5:0])),
		.window_col (signed'(s_tdata[11:6])),
		.chan       (s_tdata[17:12]),
		.value      (s_tdata[25:18]),
		.in_height  (in_height_q),
		.in_width   (in_width_q),
		.win_rows   (win_rows_q),
		.win_cols   (win_cols_q),
		.keep       (keep),
		.op         (front_op)
	);

	mpw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (front_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	mpw_back #(
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_DEPTH  (MAX_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.act_min  (act_min_q),
		.act_max  (act_max_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
